/* rtl/lfra_pkg.sv */
package lfra_pkg;

    localparam int ID_W       = 10;
    localparam int ID_SPACE   = 1 << ID_W;
    localparam int ROOM_OUT_W = 8;
    localparam int STATUS_W   = 2;

    // Busy bitmap is kept in memory words of BUSY_WORD_W rooms each.
    localparam int BIT_W       = 6;
    localparam int BUSY_WORD_W = 1 << BIT_W;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_END   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALL_BUSY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INACTIVE = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_FREE
    } state_t;

endpackage

/* rtl/lowest_free_room_allocator_top.sv */
// Channel  Direction  Ports                                   Word
// s_       in         s_valid s_ready s_func s_request_id     one booking event
// m_       out        m_valid m_ready m_room m_rooms_opened   one result per event
//                     m_status
//
// Input is held off (s_ready low) while an event is in S_LOOK, and for an end of
// an active request also in S_FREE; the accepting cycle reads the request memory
// and the busy-word memory. A start, or an end of an inactive request, loads the
// result register from S_LOOK; an active end adds a read-modify-write of the busy
// word that holds the freed room and loads the result register from S_FREE.
// After reset a clearing pass over max(MAX_REQUESTS capped at 1024, busy words)
// entries zeroes both memories; s_ready stays low meanwhile.
// The result register lets the block accept the next word while a result waits;
// a new result stalls in its final state until the result register is free.
module lowest_free_room_allocator_top
    import lfra_pkg::*;
#(
    parameter int MAX_REQUESTS = 1024,
    parameter int MAX_ROOMS    = 255
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [ID_W-1:0]       s_request_id,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ROOM_OUT_W-1:0] m_room,
    output logic [ROOM_OUT_W-1:0] m_rooms_opened,
    output logic [STATUS_W-1:0]   m_status
);

    // Only the first 1024 ids can ever be addressed by the 10-bit port.
    localparam int REQ_DEPTH = (MAX_REQUESTS < ID_SPACE) ? MAX_REQUESTS : ID_SPACE;
    localparam int RA_W      = $clog2(REQ_DEPTH);
    localparam int RW        = $clog2(MAX_ROOMS + 1);
    localparam int WORDS     = (MAX_ROOMS + BUSY_WORD_W - 1) / BUSY_WORD_W;
    localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RX_W      = WIDX_W + BIT_W;
    localparam int CLR_N     = (REQ_DEPTH > WORDS) ? REQ_DEPTH : WORDS;
    localparam int CLR_W     = $clog2(CLR_N);

    // Request memory entry: {active, room}.
    logic [RW:0]            req_mem [REQ_DEPTH];
    logic [RW:0]            req_rd_reg;
    logic                   req_rd_en;
    logic [RA_W-1:0]        req_rd_addr;
    logic                   req_we;
    logic [RA_W-1:0]        req_wr_addr;
    logic [RW:0]            req_wr_data;

    // Busy bitmap memory, one bit per room, room r at bit r-1.
    logic [BUSY_WORD_W-1:0] busy_mem [WORDS];
    logic [BUSY_WORD_W-1:0] busy_rd_reg;
    logic                   busy_rd_en;
    logic [WIDX_W-1:0]      busy_rd_addr;
    logic                   busy_we;
    logic [WIDX_W-1:0]      busy_wr_addr;
    logic [BUSY_WORD_W-1:0] busy_wr_data;

    state_t                 state_reg, state_next;
    logic [CLR_W-1:0]       clr_idx_reg, clr_idx_next;
    logic                   func_reg, func_next;
    logic                   in_range_reg, in_range_next;
    logic [RA_W-1:0]        addr_reg, addr_next;
    logic [WIDX_W-1:0]      word_sel_reg, word_sel_next;
    logic [WORDS-1:0]       word_full_reg, word_full_next;
    logic [RW-1:0]          highest_reg, highest_next;

    logic                   m_valid_reg, m_valid_next;
    logic [ROOM_OUT_W-1:0]  room_out_reg, room_out_next;
    logic [ROOM_OUT_W-1:0]  opened_out_reg, opened_out_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic                   out_free;
    logic [WIDX_W-1:0]      free_word;
    logic                   all_full;
    logic [BUSY_WORD_W-1:0] valid_mask;
    logic [BUSY_WORD_W-1:0] word_eff;
    logic [BIT_W-1:0]       free_bit;
    logic [RX_W-1:0]        new_idx;
    logic [RW-1:0]          new_room;
    logic [BUSY_WORD_W-1:0] word_set;
    logic                   entry_active;
    logic [RW-1:0]          entry_room;
    logic [RX_W-1:0]        entry_idx;

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_room         = room_out_reg;
    assign m_rooms_opened = opened_out_reg;
    assign m_status       = status_reg;

    assign out_free = !m_valid_reg || m_ready;

    // Lowest word that still has a free room.
    always_comb begin
        free_word = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (!word_full_reg[i]) begin
                free_word = WIDX_W'(i);
            end
        end
    end
    assign all_full = &word_full_reg;

    // Bits past MAX_ROOMS in the last word count as busy.
    always_comb begin
        for (int b = 0; b < BUSY_WORD_W; b++) begin
            valid_mask[b] = (int'(word_sel_reg) * BUSY_WORD_W + b) < MAX_ROOMS;
        end
    end
    assign word_eff = busy_rd_reg | ~valid_mask;

    always_comb begin
        free_bit = '0;
        for (int b = BUSY_WORD_W - 1; b >= 0; b--) begin
            if (!word_eff[b]) begin
                free_bit = BIT_W'(b);
            end
        end
    end

    assign new_idx      = {word_sel_reg, free_bit};
    assign new_room     = RW'({1'b0, new_idx} + (RX_W + 1)'(1));
    assign word_set     = busy_rd_reg | (BUSY_WORD_W'(1) << free_bit);
    assign entry_active = req_rd_reg[RW];
    assign entry_room   = req_rd_reg[RW-1:0];
    assign entry_idx    = RX_W'(entry_room) - RX_W'(1);

    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        func_next       = func_reg;
        in_range_next   = in_range_reg;
        addr_next       = addr_reg;
        word_sel_next   = word_sel_reg;
        word_full_next  = word_full_reg;
        highest_next    = highest_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        room_out_next   = room_out_reg;
        opened_out_next = opened_out_reg;
        status_next     = status_reg;

        req_rd_en    = 1'b0;
        req_rd_addr  = s_request_id[RA_W-1:0];
        req_we       = 1'b0;
        req_wr_addr  = addr_reg;
        req_wr_data  = '0;
        busy_rd_en   = 1'b0;
        busy_rd_addr = free_word;
        busy_we      = 1'b0;
        busy_wr_addr = word_sel_reg;
        busy_wr_data = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // Zero one request entry and one busy word per cycle.
                req_we       = int'(clr_idx_reg) < REQ_DEPTH;
                req_wr_addr  = clr_idx_reg[RA_W-1:0];
                busy_we      = int'(clr_idx_reg) < WORDS;
                busy_wr_addr = clr_idx_reg[WIDX_W-1:0];
                clr_idx_next = clr_idx_reg + CLR_W'(1);
                if (int'(clr_idx_reg) == CLR_N - 1) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    req_rd_en     = 1'b1;
                    busy_rd_en    = 1'b1;
                    func_next     = s_func;
                    in_range_next = int'(s_request_id) < MAX_REQUESTS;
                    addr_next     = s_request_id[RA_W-1:0];
                    word_sel_next = free_word;
                    state_next    = S_LOOK;
                end
            end

            S_LOOK: begin
                if (func_reg == FUNC_START) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        opened_out_next = ROOM_OUT_W'(highest_reg);
                        state_next      = S_IDLE;
                        if (!in_range_reg) begin
                            room_out_next = '0;
                            status_next   = STATUS_ALL_BUSY;
                        end else if (entry_active) begin
                            room_out_next = ROOM_OUT_W'(entry_room);
                            status_next   = STATUS_OK;
                        end else if (all_full) begin
                            room_out_next = '0;
                            status_next   = STATUS_ALL_BUSY;
                        end else begin
                            // Allocate: mark the bit, bind the request, track the peak.
                            busy_we                      = 1'b1;
                            busy_wr_data                 = word_set;
                            word_full_next[word_sel_reg] = &(word_set | ~valid_mask);
                            req_we                       = 1'b1;
                            req_wr_data                  = {1'b1, new_room};
                            room_out_next                = ROOM_OUT_W'(new_room);
                            status_next                  = STATUS_OK;
                            if (new_room > highest_reg) begin
                                highest_next    = new_room;
                                opened_out_next = ROOM_OUT_W'(new_room);
                            end
                        end
                    end
                end else if (!in_range_reg || !entry_active) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        room_out_next   = '0;
                        opened_out_next = ROOM_OUT_W'(highest_reg);
                        status_next     = STATUS_INACTIVE;
                        state_next      = S_IDLE;
                    end
                end else begin
                    // Release the request and fetch the word holding its room.
                    req_we        = 1'b1;
                    req_wr_data   = {1'b0, entry_room};
                    busy_rd_en    = 1'b1;
                    busy_rd_addr  = entry_idx[RX_W-1:BIT_W];
                    word_sel_next = entry_idx[RX_W-1:BIT_W];
                    state_next    = S_FREE;
                end
            end

            S_FREE: begin
                if (out_free) begin
                    busy_we                      = 1'b1;
                    busy_wr_data                 = busy_rd_reg &
                        ~(BUSY_WORD_W'(1) << entry_idx[BIT_W-1:0]);
                    word_full_next[word_sel_reg] = 1'b0;
                    m_valid_next                 = 1'b1;
                    room_out_next                = ROOM_OUT_W'(entry_room);
                    opened_out_next              = ROOM_OUT_W'(highest_reg);
                    status_next                  = STATUS_OK;
                    state_next                   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            word_full_reg <= '0;
            highest_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            word_full_reg <= word_full_next;
            highest_reg   <= highest_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        in_range_reg   <= in_range_next;
        addr_reg       <= addr_next;
        word_sel_reg   <= word_sel_next;
        room_out_reg   <= room_out_next;
        opened_out_reg <= opened_out_next;
        status_reg     <= status_next;
    end

    // Request memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (req_we) begin
            req_mem[req_wr_addr] <= req_wr_data;
        end
        if (req_rd_en) begin
            req_rd_reg <= req_mem[req_rd_addr];
        end
    end

    // Busy bitmap memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (busy_we) begin
            busy_mem[busy_wr_addr] <= busy_wr_data;
        end
        if (busy_rd_en) begin
            busy_rd_reg <= busy_mem[busy_rd_addr];
        end
    end

endmodule

/* rtl/lfra_check.sv */
module lfra_check
    import lfra_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ROOM_OUT_W-1:0] m_room,
    input logic [ROOM_OUT_W-1:0] m_rooms_opened,
    input logic [STATUS_W-1:0]   m_status
);

    // A word that succeeded names a real room.
    a_ok_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_OK) |-> (m_room != '0))
        else $error("ok result without a room");

    // A failed word carries no room.
    a_fail_no_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_OK) |-> (m_room == '0))
        else $error("failed result names a room");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_room) && $stable(m_rooms_opened) && $stable(m_status)))
        else $error("result word changed while stalled");

    // With no result waiting, an accepted input has no result yet in the cycle after it is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared one cycle after accept");

endmodule

bind lowest_free_room_allocator_top lfra_check u_lfra_check (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_room         (m_room),
    .m_rooms_opened (m_rooms_opened),
    .m_status       (m_status)
);

/* tb/tb_top.sv */
module tb_top;
    import lfra_pkg::*;

    localparam int NUM_REQUESTS = 1024;
    localparam int NUM_ROOMS    = 255;
    localparam int IDLE_PCT     = 11;

    // One result word, laid out as the m_ channel carries it.
    typedef struct packed {
        logic [ROOM_OUT_W-1:0] room;
        logic [ROOM_OUT_W-1:0] rooms_opened;
        logic [STATUS_W-1:0]   status;
    } booking_result_t;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_func         = FUNC_START;
    logic [ID_W-1:0]       s_request_id   = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [ROOM_OUT_W-1:0] m_room;
    logic [ROOM_OUT_W-1:0] m_rooms_opened;
    logic [STATUS_W-1:0]   m_status;

    // Allocation state mirrored by the testbench. room_held is read only for
    // requests marked live, so its unwritten entries are never looked at.
    logic [ROOM_OUT_W-1:0] room_held [NUM_REQUESTS];
    bit                    request_live [NUM_REQUESTS];
    bit                    room_taken [NUM_ROOMS];
    int                    highest_room;
    int                    live_count;

    // Results still owed by the block, oldest first.
    booking_result_t pending_results[$];

    // While calm is set neither side idles.
    bit calm;
    int errors;
    int events_sent;
    int busy_answers;
    int inactive_answers;
    int reused_answers;

    lowest_free_room_allocator_top #(
        .MAX_REQUESTS(NUM_REQUESTS),
        .MAX_ROOMS   (NUM_ROOMS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_request_id  (s_request_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_room        (m_room),
        .m_rooms_opened(m_rooms_opened),
        .m_status      (m_status)
    );

    always #5 aclk = ~aclk;

    // Hold reset from time zero, then release it for good.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Apply one booking event to the mirrored state and return the result the
    // block owes for it.
    function automatic booking_result_t book_event(logic func, logic [ID_W-1:0] id);
        booking_result_t res;
        int              free_room;
        res.room   = '0;
        res.status = STATUS_OK;
        if (func == FUNC_START) begin
            if (int'(id) >= NUM_REQUESTS) begin
                res.status = STATUS_ALL_BUSY;
            end else if (request_live[id]) begin
                // Repeat start: answer with the room already held.
                res.room = room_held[id];
            end else begin
                // Scan downward so the lowest free room is the one left standing.
                free_room = 0;
                for (int r = NUM_ROOMS - 1; r >= 0; r--) begin
                    if (!room_taken[r])
                        free_room = r + 1;
                end
                if (free_room == 0) begin
                    res.status = STATUS_ALL_BUSY;
                end else begin
                    if (free_room <= highest_room)
                        reused_answers++;
                    room_taken[free_room-1] = 1'b1;
                    room_held[id]           = ROOM_OUT_W'(free_room);
                    request_live[id]        = 1'b1;
                    live_count++;
                    if (free_room > highest_room)
                        highest_room = free_room;
                    res.room = ROOM_OUT_W'(free_room);
                end
            end
        end else begin
            if (int'(id) >= NUM_REQUESTS || !request_live[id]) begin
                res.status = STATUS_INACTIVE;
            end else begin
                res.room         = room_held[id];
                request_live[id] = 1'b0;
                live_count--;
                if (room_held[id] >= 1 && int'(room_held[id]) <= NUM_ROOMS)
                    room_taken[room_held[id]-1] = 1'b0;
            end
        end
        res.rooms_opened = ROOM_OUT_W'(highest_room);
        return res;
    endfunction

    // Find a request id that is live (or not), starting from a random point.
    function automatic int pick_id(bit want_live);
        int base;
        int id;
        base = $urandom_range(0, NUM_REQUESTS - 1);
        for (int k = 0; k < NUM_REQUESTS; k++) begin
            id = (base + k) % NUM_REQUESTS;
            if (request_live[id] == want_live)
                return id;
        end
        return base;
    endfunction

    // Send one event word. Valid is left high after acceptance so that a
    // following word can go out back to back; whoever pauses drops it.
    task automatic send_event(input logic func, input logic [ID_W-1:0] id);
        booking_result_t res;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_request_id <= id;
        do @(posedge aclk); while (!s_ready);
        res = book_event(func, id);
        pending_results.push_back(res);
        events_sent++;
        if (res.status == STATUS_ALL_BUSY)
            busy_answers++;
        if (res.status == STATUS_INACTIVE)
            inactive_answers++;
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver: stall at random, except during calm stretches.
    always @(posedge aclk)
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Compare every accepted result word with the oldest one owed.
    always @(posedge aclk) begin
        booking_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result room=%0d rooms_opened=%0d status=%0d",
                         $time, m_room, m_rooms_opened, m_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_room !== want.room) begin
                    $display("%0t: room expected %0d actual %0d", $time, want.room, m_room);
                    errors++;
                end
                if (m_rooms_opened !== want.rooms_opened) begin
                    $display("%0t: rooms_opened expected %0d actual %0d",
                             $time, want.rooms_opened, m_rooms_opened);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                    errors++;
                end
            end
        end
    end

    // Extreme ids, repeat start, end of an inactive or never-seen request,
    // and reuse of the lowest freed room.
    task automatic test_edge_events();
        send_event(FUNC_START, 10'd0);
        send_event(FUNC_START, 10'd1023);
        send_event(FUNC_START, 10'd0);
        send_event(FUNC_END,   10'd0);
        send_event(FUNC_END,   10'd0);
        send_event(FUNC_END,   10'b1010101010);
        // Let the block drain completely before going on.
        pause_until_drained();
        send_event(FUNC_START, 10'b0101010101);
        send_event(FUNC_START, 10'd512);
        send_event(FUNC_END,   10'd1023);
        send_event(FUNC_START, 10'd1);
        send_event(FUNC_END,   10'b0101010101);
        send_event(FUNC_END,   10'd512);
        send_event(FUNC_END,   10'd1);
        send_event(FUNC_START, 10'd1023);
        send_event(FUNC_END,   10'd1023);
    endtask

    // Open every room, then knock on the full house; runs with no idling.
    task automatic test_all_rooms_busy();
        int id;
        calm = 1'b1;
        while (live_count < NUM_ROOMS)
            send_event(FUNC_START, ID_W'(pick_id(1'b0)));
        repeat (3)
            send_event(FUNC_START, ID_W'(pick_id(1'b0)));
        send_event(FUNC_START, ID_W'(pick_id(1'b1)));
        // Free one room and take it straight back.
        id = pick_id(1'b1);
        send_event(FUNC_END, ID_W'(id));
        send_event(FUNC_START, ID_W'(pick_id(1'b0)));
        calm = 1'b0;
    endtask

    // Mostly well-formed traffic: starts of idle requests and ends of live
    // ones, with some repeat starts and stray ends mixed in.
    task automatic test_random_traffic(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 46)
                send_event(FUNC_START, ID_W'(pick_id(1'b0)));
            else if (pick < 86 && live_count > 0)
                send_event(FUNC_END, ID_W'(pick_id(1'b1)));
            else if (pick < 93)
                send_event(FUNC_END, ID_W'($urandom_range(0, NUM_REQUESTS - 1)));
            else
                send_event(FUNC_START, ID_W'($urandom_range(0, NUM_REQUESTS - 1)));
            if ($urandom_range(0, 99) == 0)
                pause_until_drained();
        end
    endtask

    initial begin
        // Start driving only at a clock edge after reset has been released.
        wait (aresetn === 1'b1);
        @(posedge aclk);
        test_edge_events();
        test_all_rooms_busy();
        test_random_traffic(280);
        pause_until_drained();
        repeat (10) @(posedge aclk);
        $display("covered %0d events: %0d all-busy, %0d inactive-end, %0d reused rooms",
                 events_sent, busy_answers, inactive_answers, reused_answers);
        $display("peak rooms opened %0d of %0d; %0d mismatches",
                 highest_room, NUM_ROOMS, errors);
        if (errors == 0)
            $display("lowest_free_room_allocator_top regression: pass");
        else
            $display("lowest_free_room_allocator_top regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, clearing pass included.
    initial begin
        #1000000;
        $display("lowest_free_room_allocator_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/lfra_pkg.sv
rtl/lowest_free_room_allocator_top.sv
rtl/lfra_check.sv
tb/tb_top.sv
